// File: rtl/tdbm_pkg.sv
// ============================================================================
// tdbm_pkg
// Shared types, codes and helpers of the transmit descriptor buffer manager.
// ============================================================================
package tdbm_pkg;

    localparam int MAX_QUEUE_DEF = 256;     // default descriptor count
    localparam int PAGE_BYTES    = 4096;    // largest frame incl. headers
    localparam int ETH_HDR_BYTES = 14;
    localparam int STACK_DEPTH   = 256;
    localparam int STACK_AW      = 8;
    localparam int DESC_W        = 8;
    localparam int LEN_W         = 13;
    localparam int TOTAL_W       = 17;
    localparam int CNT_W         = 16;
    localparam int FC_W          = 9;
    localparam int QS_W          = 9;
    localparam int GRP_COUNT     = 16;
    localparam int GRP_SIZE      = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;
    localparam int SDATA_W       = 40;
    localparam int MDATA_W       = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd2;

    localparam logic [3:0] QLOG_RESET = 4'd8;
    localparam logic [3:0] QLOG_MAX   = 4'd8;
    localparam logic [3:0] HDR_RESET  = 4'd12;

    typedef enum logic [1:0] {
        OP_TRANSMIT = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_ADD_BUF  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_NO_BUFFER = 3'd3,
        ST_NO_DESC   = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic latch;    // take the input item
        logic read;     // memory reads, first search level
        logic search;   // second search level
        logic commit;   // update state, load the result register
    } t_cmd;

    function automatic logic [2:0] pri8(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    // lowest set bit of a 16-bit vector (8 when none is set)
    function automatic logic [3:0] lowest16(input logic [15:0] v);
        logic       hi;
        logic [7:0] half;
        hi   = ~|v[7:0];
        half = hi ? v[15:8] : v[7:0];
        return {hi, pri8(half)};
    endfunction

endpackage

// File: rtl/tdbm_ctrl.sv
// ============================================================================
// tdbm_ctrl
// Sequencer: accept one item, read, search, commit into the output register.
// ============================================================================
module tdbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output tdbm_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SRCH,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_m_tvalid;
    logic   out_free;

    assign out_free   = !r_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;

    assign o_cmd.latch  = i_s_tvalid && (r_state == S_IDLE);
    assign o_cmd.read   = (r_state == S_READ);
    assign o_cmd.search = (r_state == S_SRCH);
    assign o_cmd.commit = (r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.commit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/tdbm_dp.sv
// ============================================================================
// tdbm_dp
// Datapath: config registers, free stack, descriptor map, in-flight bits,
// two-level lowest-free search, ring counters and the result register.
// ============================================================================
module tdbm_dp #(
    parameter int MAX_QUEUE = tdbm_pkg::MAX_QUEUE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdbm_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_wr_en,
    input  logic [tdbm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [tdbm_pkg::SDATA_W-1:0]        i_s_tdata,
    input  logic [1:0]                          i_s_tuser,
    output logic [tdbm_pkg::MDATA_W-1:0]        o_m_tdata,
    output logic [2:0]                          o_m_tuser
);

    localparam int IDXW = (MAX_QUEUE > 1) ? $clog2(MAX_QUEUE) : 1;

    // configuration
    logic [3:0] r_qlog;
    logic [3:0] r_hdr;
    logic       r_en;

    // latched item
    logic [1:0]  r_op;
    logic [15:0] r_payload;
    logic [15:0] r_used_id;
    logic [7:0]  r_buf;

    // state
    logic [tdbm_pkg::FC_W-1:0]  r_free_count;
    logic [tdbm_pkg::CNT_W-1:0] r_avail;
    logic [tdbm_pkg::CNT_W-1:0] r_used;
    logic [MAX_QUEUE-1:0]       r_in_flight;
    logic [7:0]                 r_stack [tdbm_pkg::STACK_DEPTH];
    logic [7:0]                 r_map   [MAX_QUEUE];
    logic [7:0]                 r_stk_rd;
    logic [7:0]                 r_map_rd;

    // search pipeline
    logic [tdbm_pkg::GRP_COUNT-1:0] r_grp_any;
    logic [3:0]                     r_grp_idx [tdbm_pkg::GRP_COUNT];
    logic [tdbm_pkg::DESC_W-1:0]    r_found;
    logic                           r_have;

    // result register
    logic [tdbm_pkg::MDATA_W-1:0] r_m_tdata;
    logic [2:0]                   r_m_tuser;

    // combinational
    logic [3:0]                          qlog_c;
    logic [tdbm_pkg::QS_W-1:0]           q_pow;
    logic [tdbm_pkg::QS_W-1:0]           q;
    logic [7:0]                          q_mask;
    logic [tdbm_pkg::GRP_COUNT*tdbm_pkg::GRP_SIZE-1:0] free_vec;
    logic [tdbm_pkg::GRP_COUNT-1:0]      grp_any;
    logic [3:0]                          grp_idx [tdbm_pkg::GRP_COUNT];
    logic [3:0]                          grp_sel;
    logic [tdbm_pkg::TOTAL_W-1:0]        total;
    logic                                id_live;
    logic [IDXW-1:0]                     id_idx;
    logic [IDXW-1:0]                     found_idx;

    tdbm_pkg::t_status            st;
    logic [7:0]                   res_desc;
    logic [7:0]                   res_pool;
    logic [7:0]                   res_slot;
    logic [tdbm_pkg::LEN_W-1:0]   res_len;
    logic                         res_kick;
    logic                         stk_we;
    logic [7:0]                   stk_wd;
    logic                         map_we;
    logic                         set_flight;
    logic                         clr_flight;
    logic                         avail_inc;
    logic                         used_inc;
    logic [tdbm_pkg::FC_W-1:0]    n_free_count;

    // queue size: 1 << min(log2, 8), capped at MAX_QUEUE
    assign qlog_c = (r_qlog > tdbm_pkg::QLOG_MAX) ? tdbm_pkg::QLOG_MAX : r_qlog;
    assign q_pow  = tdbm_pkg::QS_W'(1) << qlog_c;
    assign q      = (q_pow > tdbm_pkg::QS_W'(MAX_QUEUE)) ? tdbm_pkg::QS_W'(MAX_QUEUE) : q_pow;
    assign q_mask = 8'(q - tdbm_pkg::QS_W'(1));

    assign id_idx    = r_used_id[IDXW-1:0];
    assign found_idx = r_found[IDXW-1:0];

    // first search level: per group any-free and lowest free offset
    always_comb begin
        free_vec = '0;
        for (int d = 0; d < MAX_QUEUE; d++) begin
            free_vec[d] = !r_in_flight[d] && (tdbm_pkg::QS_W'(d) < q);
        end
        for (int g = 0; g < tdbm_pkg::GRP_COUNT; g++) begin
            grp_any[g] = |free_vec[g*tdbm_pkg::GRP_SIZE +: tdbm_pkg::GRP_SIZE];
            grp_idx[g] = tdbm_pkg::lowest16(
                free_vec[g*tdbm_pkg::GRP_SIZE +: tdbm_pkg::GRP_SIZE]);
        end
    end

    assign grp_sel = tdbm_pkg::lowest16(r_grp_any);

    // commit decision
    always_comb begin
        total        = tdbm_pkg::TOTAL_W'(r_hdr) + tdbm_pkg::TOTAL_W'(tdbm_pkg::ETH_HDR_BYTES)
                     + tdbm_pkg::TOTAL_W'(r_payload);
        id_live      = (r_used_id < 16'(q)) && r_in_flight[id_idx];
        st           = tdbm_pkg::ST_IGNORED;
        res_desc     = 8'd0;
        res_pool     = 8'd0;
        res_slot     = 8'd0;
        res_len      = '0;
        res_kick     = 1'b0;
        stk_we       = 1'b0;
        stk_wd       = r_buf;
        map_we       = 1'b0;
        set_flight   = 1'b0;
        clr_flight   = 1'b0;
        avail_inc    = 1'b0;
        used_inc     = 1'b0;
        n_free_count = r_free_count;

        case (tdbm_pkg::t_op'(r_op))
            tdbm_pkg::OP_TRANSMIT: begin
                if (!r_en) begin
                    st = tdbm_pkg::ST_NOT_READY;
                end else begin
                    res_len = total[tdbm_pkg::LEN_W-1:0];
                    if (total > tdbm_pkg::TOTAL_W'(tdbm_pkg::PAGE_BYTES)) begin
                        st = tdbm_pkg::ST_TOO_LONG;
                    end else if (r_free_count == '0) begin
                        st = tdbm_pkg::ST_NO_BUFFER;
                    end else if (!r_have) begin
                        // no pop: the stack is left as it was
                        st = tdbm_pkg::ST_NO_DESC;
                    end else begin
                        st           = tdbm_pkg::ST_OK;
                        res_desc     = r_found;
                        res_pool     = r_stk_rd;
                        res_slot     = r_avail[7:0] & q_mask;
                        res_kick     = 1'b1;
                        map_we       = 1'b1;
                        set_flight   = 1'b1;
                        avail_inc    = 1'b1;
                        n_free_count = r_free_count - tdbm_pkg::FC_W'(1);
                    end
                end
            end
            tdbm_pkg::OP_COMPLETE: begin
                if (!r_en) begin
                    st = tdbm_pkg::ST_NOT_READY;
                end else begin
                    res_slot = r_used[7:0] & q_mask;
                    used_inc = 1'b1;
                    if (id_live) begin
                        clr_flight = 1'b1;
                        res_desc   = r_used_id[7:0];
                        res_pool   = r_map_rd;
                        stk_wd     = r_map_rd;
                        if ((tdbm_pkg::QS_W'(r_map_rd) < q) && !r_free_count[tdbm_pkg::FC_W-1]) begin
                            st           = tdbm_pkg::ST_OK;
                            stk_we       = 1'b1;
                            n_free_count = r_free_count + tdbm_pkg::FC_W'(1);
                        end
                    end
                end
            end
            tdbm_pkg::OP_ADD_BUF: begin
                if (!r_free_count[tdbm_pkg::FC_W-1]) begin
                    st           = tdbm_pkg::ST_OK;
                    res_pool     = r_buf;
                    stk_we       = 1'b1;
                    n_free_count = r_free_count + tdbm_pkg::FC_W'(1);
                end
            end
            default: begin
                st = tdbm_pkg::ST_IGNORED;
            end
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlog       <= tdbm_pkg::QLOG_RESET;
            r_hdr        <= tdbm_pkg::HDR_RESET;
            r_en         <= 1'b0;
            r_free_count <= '0;
            r_avail      <= '0;
            r_used       <= '0;
            r_in_flight  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    tdbm_pkg::CFG_QUEUE_LOG2: r_qlog <= i_cfg_data;
                    tdbm_pkg::CFG_HEADER_LEN: r_hdr  <= i_cfg_data;
                    tdbm_pkg::CFG_ENABLE:     r_en   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_free_count <= n_free_count;
                if (avail_inc) begin
                    r_avail <= r_avail + tdbm_pkg::CNT_W'(1);
                end
                if (used_inc) begin
                    r_used <= r_used + tdbm_pkg::CNT_W'(1);
                end
                if (set_flight) begin
                    r_in_flight[found_idx] <= 1'b1;
                end
                if (clr_flight) begin
                    r_in_flight[id_idx] <= 1'b0;
                end
            end
        end
    end

    // payload, memories and pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= i_s_tuser;
            r_payload <= i_s_tdata[15:0];
            r_used_id <= i_s_tdata[31:16];
            r_buf     <= i_s_tdata[39:32];
        end
        if (i_cmd.read) begin
            r_stk_rd  <= r_stack[tdbm_pkg::STACK_AW'(r_free_count - tdbm_pkg::FC_W'(1))];
            r_map_rd  <= r_map[id_idx];
            r_grp_any <= grp_any;
            r_grp_idx <= grp_idx;
        end
        if (i_cmd.search) begin
            r_found <= {grp_sel, r_grp_idx[grp_sel]};
            r_have  <= |r_grp_any;
        end
        if (i_cmd.commit) begin
            if (stk_we) begin
                r_stack[r_free_count[tdbm_pkg::STACK_AW-1:0]] <= stk_wd;
            end
            if (map_we) begin
                r_map[found_idx] <= r_stk_rd;
            end
            r_m_tuser <= st;
            r_m_tdata <= {2'b00, res_kick, res_len, res_slot, res_pool, res_desc};
        end
    end

    assign o_m_tdata = r_m_tdata;
    assign o_m_tuser = r_m_tuser;

endmodule

// File: rtl/tx_descriptor_buffer_manager.sv
// ============================================================================
// tx_descriptor_buffer_manager
// An accepted item passes the read, search and commit states before its result
// is valid; commit waits only while the output register is still held by the sink.
// A new item is accepted only once the previous result has been committed; the
// lowest-free-descriptor search is two-level and registered.
// Reset (synchronous, active low) clears counters, free count and in-flight
// bits and returns the config registers to their defaults.
// ============================================================================
module tx_descriptor_buffer_manager #(
    parameter int MAX_QUEUE = tdbm_pkg::MAX_QUEUE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration write port: 0 queue_size_log2, 1 header_length, 2 enable
    input  logic                                i_cfg_wr_en,
    input  logic [tdbm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tdbm_pkg::SDATA_W-1:0]        s_tdata,   // payload_length[15:0],
                                                           // used_id[31:16],
                                                           // buffer_index[39:32]
    input  logic [1:0]                          s_tuser,   // op[1:0]

    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tdbm_pkg::MDATA_W-1:0]        m_tdata,   // descriptor_index[7:0],
                                                           // pool_index[15:8],
                                                           // ring_slot[23:16],
                                                           // descriptor_length[36:24],
                                                           // kick[37], zero[39:38]
    output logic [2:0]                          m_tuser    // status[2:0]
);

    tdbm_pkg::t_cmd cmd;

    // Sequencer: one item in flight; the input side reopens as soon as the
    // result is parked in the output register.
    tdbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_cmd      (cmd)
    );

    // Datapath: free stack, descriptor-to-buffer map, in-flight bits,
    // lowest-free search, ring counters and the result register.
    tdbm_dp #(
        .MAX_QUEUE (MAX_QUEUE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

`ifndef SYNTH
    // an accepted item closes the input until its result is committed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened right after accept");

    // a kick only comes with a successful transmit
    a_kick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[37] |-> m_tuser == tdbm_pkg::ST_OK)
        else $error("kick without ok status");

    // a not-ready result carries all-zero data: no indices, no length and no kick
    a_not_ready_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == tdbm_pkg::ST_NOT_READY) |-> m_tdata[37:0] == '0)
        else $error("not-ready result carries data");
`endif

endmodule
